// ===== design/gn3_pkg.sv =====
// Shared constants, permutation table and gradient helpers for the 3-D gradient noise block.
`timescale 1ns / 1ps
package gn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 8 + FRAC_BITS;
  localparam int VAL_W     = 20;

  localparam logic [COORD_W-1:0] X_OFFSET =
      COORD_W'(((longint'(123456) << FRAC_BITS) + 500) / 1000);
  localparam int TURB_BIAS = 19661;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
    8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
    8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
    8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
    8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
    8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM[idx];
  endfunction

  // fraction bits rescaled to Q16
  function automatic logic [15:0] frac_q16(input logic [COORD_W-1:0] c);
    logic [FRAC_BITS+15:0] tmp;
    tmp = {c[FRAC_BITS-1:0], 16'b0};
    return tmp[FRAC_BITS+15 -: 16];
  endfunction

  function automatic logic signed [VAL_W-1:0] corner_dot(input logic [3:0] h,
                                                         input logic signed [17:0] x,
                                                         input logic signed [17:0] y,
                                                         input logic signed [17:0] z);
    logic signed [VAL_W-1:0] gu;
    logic signed [VAL_W-1:0] gv;
    gu = (h < 4'd8) ? VAL_W'(x) : VAL_W'(y);
    if (h < 4'd4) begin
      gv = VAL_W'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = VAL_W'(x);
    end else begin
      gv = VAL_W'(z);
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

endpackage

// ===== design/gn3_fade.sv =====
// Four-stage pipelined quintic fade curve in Q16.
`timescale 1ns / 1ps
module gn3_fade import gn3_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] t_i,
  output logic [16:0] fade_o
);

  logic [31:0] t2_q;
  logic [19:0] t15_q;
  logic [15:0] t1_q;
  logic [37:0] inner_q;
  logic [31:0] t3f_q;
  logic [35:0] prod_q;
  logic [16:0] fade_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q    <= 32'(t_i) * 32'(t_i);
      t15_q   <= 20'(t_i) * 20'd15;
      t1_q    <= t_i;
      inner_q <= 38'(t2_q) * 38'd6 + (38'd10 << 32) - (38'(t15_q) << 16);
      t3f_q   <= 32'(t2_q[31:16]) * 32'(t1_q);
      prod_q  <= 36'(t3f_q[31:16]) * 36'(inner_q[35:16]);
      fade_q  <= prod_q[32:16];
    end
  end

  assign fade_o = fade_q;

endmodule

// ===== design/gn3_lattice.sv =====
// Eight-stage pipeline for one lattice noise evaluation: hash, gradients, trilinear blend.
`timescale 1ns / 1ps
module gn3_lattice import gn3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [COORD_W-1:0]      cx_i,
  input  logic [COORD_W-1:0]      cy_i,
  input  logic [COORD_W-1:0]      cz_i,
  output logic signed [VAL_W-1:0] noise_o
);

  logic [15:0] fx, fy, fz;
  logic [16:0] u4, v4, w4;

  assign fx = frac_q16(cx_i);
  assign fy = frac_q16(cy_i);
  assign fz = frac_q16(cz_i);

  gn3_fade u_fade_x (.clk_i, .en_i, .t_i(fx), .fade_o(u4));
  gn3_fade u_fade_y (.clk_i, .en_i, .t_i(fy), .fade_o(v4));
  gn3_fade u_fade_z (.clk_i, .en_i, .t_i(fz), .fade_o(w4));

  logic [7:0]  pa_q, pb_q, yi1_q, zi1_q;
  logic [7:0]  aa_q, ab_q, ba_q, bb_q;
  logic [3:0]  h_q [8];
  logic [15:0] fx_q [3];
  logic [15:0] fy_q [3];
  logic [15:0] fz_q [3];
  logic signed [VAL_W-1:0] d_q [8];
  logic signed [37:0] px_q [4];
  logic signed [VAL_W-1:0] lo5_q [4];
  logic [16:0] v5_q, w5_q, w6_q;
  logic signed [38:0] py_q [2];
  logic signed [VAL_W-1:0] lo6_q [2];
  logic signed [38:0] pz_q;
  logic signed [VAL_W-1:0] m0_q;
  logic signed [VAL_W-1:0] n_q;

  logic [7:0] a, b;
  assign a = pa_q + yi1_q;
  assign b = pb_q + yi1_q;

  logic signed [17:0] xs [2];
  logic signed [17:0] ys [2];
  logic signed [17:0] zs [2];
  logic signed [VAL_W-1:0] dots [8];

  always_comb begin
    xs[0] = $signed({2'b0, fx_q[2]});
    ys[0] = $signed({2'b0, fy_q[2]});
    zs[0] = $signed({2'b0, fz_q[2]});
    xs[1] = xs[0] - 18'sd65536;
    ys[1] = ys[0] - 18'sd65536;
    zs[1] = zs[0] - 18'sd65536;
    for (int i = 0; i < 8; i++) begin
      dots[i] = corner_dot(h_q[i], xs[i%2], ys[(i/2)%2], zs[i/4]);
    end
  end

  logic signed [VAL_W:0] dx [4];
  logic signed [37:0] pxs [4];
  logic signed [VAL_W-1:0] l [4];
  logic signed [VAL_W:0] dy [2];
  logic signed [38:0] pys [2];
  logic signed [VAL_W-1:0] m [2];
  logic signed [VAL_W:0] dz;
  logic signed [38:0] pzs;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dx[k]  = (VAL_W+1)'(d_q[2*k+1]) - (VAL_W+1)'(d_q[2*k]);
      pxs[k] = px_q[k] >>> 16;
      l[k]   = lo5_q[k] + $signed(pxs[k][VAL_W-1:0]);
    end
    for (int j = 0; j < 2; j++) begin
      dy[j]  = (VAL_W+1)'(l[2*j+1]) - (VAL_W+1)'(l[2*j]);
      pys[j] = py_q[j] >>> 16;
      m[j]   = lo6_q[j] + $signed(pys[j][VAL_W-1:0]);
    end
    dz  = (VAL_W+1)'(m[1]) - (VAL_W+1)'(m[0]);
    pzs = pz_q >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= perm(cx_i[FRAC_BITS+7:FRAC_BITS]);
      pb_q    <= perm(cx_i[FRAC_BITS+7:FRAC_BITS] + 8'd1);
      yi1_q   <= cy_i[FRAC_BITS+7:FRAC_BITS];
      zi1_q   <= cz_i[FRAC_BITS+7:FRAC_BITS];
      fx_q[0] <= fx;
      fy_q[0] <= fy;
      fz_q[0] <= fz;

      aa_q    <= perm(a) + zi1_q;
      ab_q    <= perm(a + 8'd1) + zi1_q;
      ba_q    <= perm(b) + zi1_q;
      bb_q    <= perm(b + 8'd1) + zi1_q;
      fx_q[1] <= fx_q[0];
      fy_q[1] <= fy_q[0];
      fz_q[1] <= fz_q[0];

      h_q[0]  <= 4'(perm(aa_q));
      h_q[1]  <= 4'(perm(ba_q));
      h_q[2]  <= 4'(perm(ab_q));
      h_q[3]  <= 4'(perm(bb_q));
      h_q[4]  <= 4'(perm(aa_q + 8'd1));
      h_q[5]  <= 4'(perm(ba_q + 8'd1));
      h_q[6]  <= 4'(perm(ab_q + 8'd1));
      h_q[7]  <= 4'(perm(bb_q + 8'd1));
      fx_q[2] <= fx_q[1];
      fy_q[2] <= fy_q[1];
      fz_q[2] <= fz_q[1];

      for (int i = 0; i < 8; i++) d_q[i] <= dots[i];

      for (int k = 0; k < 4; k++) begin
        px_q[k]  <= $signed({1'b0, u4}) * dx[k];
        lo5_q[k] <= d_q[2*k];
      end
      v5_q <= v4;
      w5_q <= w4;

      for (int j = 0; j < 2; j++) begin
        py_q[j]  <= $signed({1'b0, v5_q}) * dy[j];
        lo6_q[j] <= l[2*j];
      end
      w6_q <= w5_q;

      pz_q <= $signed({1'b0, w6_q}) * dz;
      m0_q <= m[0];

      n_q  <= m0_q + $signed(pzs[VAL_W-1:0]);
    end
  end

  assign noise_o = n_q;

endmodule

// ===== design/gradient_noise_3d.sv =====
// Top level: 3-D gradient noise and three-octave turbulence, one point per clock unless stalled.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | coord_x_i, coord_y_i, coord_z_i
//   out     | output    | out_valid_o / out_stall_i  | noise_value_o, pixel_level_o
//   cfg     | input     | APB psel/penable/pwrite    | noise_mode at byte address 0
//
// One transaction per clock unless the output stalls; path: input register, eight
// lattice stages (hash ROM chain, blend multipliers), sum register, output register.
// Three lattice pipelines run side by side for the turbulence octaves.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears valid bits and noise_mode.
`timescale 1ns / 1ps
module gradient_noise_3d import gn3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [COORD_W-1:0]   coord_x_i,
  input  logic [COORD_W-1:0]   coord_y_i,
  input  logic [COORD_W-1:0]   coord_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   noise_value_o,
  output logic [7:0]           pixel_level_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int NSTG = 11;

  logic mode_q;
  logic [NSTG-1:0] vld_q;
  logic en;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      mode_q <= pwdata[0];
    end
  end

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  logic [COORD_W-1:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= mode_q ? coord_x_i + X_OFFSET : coord_x_i;
      y0_q <= coord_y_i;
      z0_q <= coord_z_i;
    end
  end

  logic signed [VAL_W-1:0] n1, n2, n4;

  gn3_lattice u_oct1 (.clk_i, .en_i(en), .cx_i(x0_q), .cy_i(y0_q), .cz_i(z0_q),
                      .noise_o(n1));
  gn3_lattice u_oct2 (.clk_i, .en_i(en), .cx_i({x0_q[COORD_W-2:0], 1'b0}),
                      .cy_i({y0_q[COORD_W-2:0], 1'b0}), .cz_i({z0_q[COORD_W-2:0], 1'b0}),
                      .noise_o(n2));
  gn3_lattice u_oct4 (.clk_i, .en_i(en), .cx_i({x0_q[COORD_W-3:0], 2'b0}),
                      .cy_i({y0_q[COORD_W-3:0], 2'b0}), .cz_i({z0_q[COORD_W-3:0], 2'b0}),
                      .noise_o(n4));

  logic [VAL_W-1:0] mag1, mag2, mag4;
  logic signed [22:0] sum_d, sum_q;

  always_comb begin
    mag1 = n1[VAL_W-1] ? VAL_W'(-n1) : VAL_W'(n1);
    mag2 = n2[VAL_W-1] ? VAL_W'(-n2) : VAL_W'(n2);
    mag4 = n4[VAL_W-1] ? VAL_W'(-n4) : VAL_W'(n4);
    if (mode_q) begin
      sum_d = $signed(23'(mag1) + 23'(mag2 >> 1) + 23'(mag4 >> 3) - 23'(TURB_BIAS));
    end else begin
      sum_d = 23'(n1);
    end
  end

  logic signed [22:0] q_full;
  logic signed [15:0] q12;
  logic signed [11:0] pix_s;
  logic [7:0] pix;

  always_comb begin
    q_full = sum_q >>> 4;
    if (q_full > 23'sd32767) begin
      q12 = 16'sh7fff;
    end else if (q_full < -23'sd32768) begin
      q12 = 16'sh8000;
    end else begin
      q12 = q_full[15:0];
    end
    pix_s = $signed({q12[15], q12[15:5]}) + 12'sd128;
    if (pix_s < 12'sd0) begin
      pix = 8'd0;
    end else if (pix_s > 12'sd255) begin
      pix = 8'd255;
    end else begin
      pix = pix_s[7:0];
    end
  end

  logic signed [15:0] noise_q;
  logic [7:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= sum_d;
      noise_q <= q12;
      pix_q   <= pix;
    end
  end

  assign noise_value_o = noise_q;
  assign pixel_level_o = pix_q;

  a_pix_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_level_o == 8'd255 |-> noise_value_o >= 16'sd4064)
    else $error("full-scale pixel with low noise value");

  a_pix_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_level_o == 8'd0 |-> noise_value_o < -16'sd4064)
    else $error("zero pixel with high noise value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q[NSTG-2]))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/gradient_noise_3d_test.sv =====
// Self-checking testbench for gradient_noise_3d: noise and turbulence points against a predictor.
`timescale 1ns / 1ps
module gradient_noise_3d_test;
  import gn3_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         pixel;
  } sample_t;

  localparam int         LATENCY    = 11;
  localparam logic [2:0] ADDR_MODE  = 3'd0;
  localparam logic       MODE_NOISE = 1'b0;
  localparam logic       MODE_TURB  = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [COORD_W-1:0] coord_x_i = '0;
  logic [COORD_W-1:0] coord_y_i = '0;
  logic [COORD_W-1:0] coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] noise_value_o;
  logic [7:0] pixel_level_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gradient_noise_3d DUT (.*);

  always #6 clk_i = ~clk_i;

  point_t  pending_points[$];
  sample_t expected_samples[$];
  logic    mode_shadow = MODE_NOISE;
  int      send_idle_pct = 31;
  int      recv_idle_pct = 88;
  int      error_count = 0;
  int      checked_count = 0;
  int      turb_count = 0;

  // fade, lerp and gradient arithmetic in signed 64-bit Q16
  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint fade16(longint t);
    longint inner, t3;
    inner = 6 * t * t - 15 * t * 65536 + 10 * 64'sd65536 * 65536;
    inner = inner >>> 16;
    t3 = (t * t) >>> 16;
    t3 = (t3 * t) >>> 16;
    return (t3 * inner) >>> 16;
  endfunction

  function automatic longint lerp16(longint t, longint a, longint b);
    return a + floor_div(t * (b - a), 16);
  endfunction

  function automatic longint grad16(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lattice16(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                       logic [COORD_W-1:0] cz);
    logic [7:0] xi, yi, zi, a, b, aa, ab, ba, bb;
    longint x, y, z, u, v, w, x1, y1, z1;
    xi = cx[COORD_W-1 -: 8];
    yi = cy[COORD_W-1 -: 8];
    zi = cz[COORD_W-1 -: 8];
    x = longint'(cx[FRAC_BITS-1:0]) << 16 >> FRAC_BITS;
    y = longint'(cy[FRAC_BITS-1:0]) << 16 >> FRAC_BITS;
    z = longint'(cz[FRAC_BITS-1:0]) << 16 >> FRAC_BITS;
    u = fade16(x);
    v = fade16(y);
    w = fade16(z);
    x1 = x - 65536;
    y1 = y - 65536;
    z1 = z - 65536;
    a  = PERM[xi] + yi;
    aa = PERM[a] + zi;
    ab = PERM[8'(a + 1)] + zi;
    b  = PERM[8'(xi + 1)] + yi;
    ba = PERM[b] + zi;
    bb = PERM[8'(b + 1)] + zi;
    return lerp16(w,
      lerp16(v, lerp16(u, grad16(PERM[aa], x, y, z), grad16(PERM[ba], x1, y, z)),
                lerp16(u, grad16(PERM[ab], x, y1, z), grad16(PERM[bb], x1, y1, z))),
      lerp16(v, lerp16(u, grad16(PERM[8'(aa + 1)], x, y, z1),
                          grad16(PERM[8'(ba + 1)], x1, y, z1)),
                lerp16(u, grad16(PERM[8'(ab + 1)], x, y1, z1),
                          grad16(PERM[8'(bb + 1)], x1, y1, z1))));
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic sample_t predict_sample(point_t p, logic mode);
    sample_t s;
    longint val, q12, pix;
    logic [COORD_W-1:0] x0;
    if (mode == MODE_NOISE) begin
      val = lattice16(p.x, p.y, p.z);
    end else begin
      x0 = p.x + X_OFFSET;
      val = mag(lattice16(x0, p.y, p.z))
          + (mag(lattice16(x0 << 1, p.y << 1, p.z << 1)) >> 1)
          + (mag(lattice16(x0 << 2, p.y << 2, p.z << 2)) >> 3) - 19661;
    end
    q12 = val >>> 4;
    if (q12 > 32767) q12 = 32767;
    if (q12 < -32768) q12 = -32768;
    pix = (q12 >>> 5) + 128;
    if (pix < 0) pix = 0;
    if (pix > 255) pix = 255;
    s.value = 16'(q12);
    s.pixel = 8'(pix);
    return s;
  endfunction

  // driver
  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        void'(pending_points.pop_front());
        expected_samples.push_back(predict_sample({coord_x_i, coord_y_i, coord_z_i},
                                                  mode_shadow));
        if (mode_shadow == MODE_TURB) turb_count++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_points[0];
          in_valid_i <= 1'b1;
          coord_x_i <= p.x;
          coord_y_i <= p.y;
          coord_z_i <= p.z;
        end else begin
          in_valid_i <= 1'b0;
          coord_x_i <= COORD_W'($urandom);
          coord_y_i <= COORD_W'($urandom);
          coord_z_i <= COORD_W'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected transaction: value %0d pixel %0d", noise_value_o, pixel_level_o);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (noise_value_o !== want.value) begin
            $error("noise_value: expected %0d, actual %0d", want.value, noise_value_o);
            error_count++;
          end
          if (pixel_level_o !== want.pixel) begin
            $error("pixel_level: expected %0d, actual %0d", want.pixel, pixel_level_o);
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_mode(logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MODE; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_shadow = data[0];
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_samples.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    pending_points.push_back('{x, y, z});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        1: add_point({8'($urandom), 16'($urandom_range(3))}, COORD_W'($urandom),
                     {8'($urandom), 16'hFFFF - 16'($urandom_range(3))});
        default: add_point(COORD_W'($urandom_range(32'hFFFFF)),
                           COORD_W'($urandom_range(32'hFFFFF)), COORD_W'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: lattice points, extremes, wrap, turbulence
    add_point('0, '0, '0);
    add_point('1, '1, '1);
    add_point(24'h008000, 24'h008000, 24'h008000);
    add_point(24'hFF0000, 24'h00FFFF, 24'h7FFFFF);
    add_point(24'hAAAAAA, 24'h555555, 24'hF0F0F0);
    add_point(24'h0F0F0F, 24'hFFFFFF, 24'h000001);
    add_point(24'h123456, 24'h654321, 24'hABCDEF);
    drain();
    write_mode(32'hFFFF_FFFE);
    write_mode(32'h0000_0001);
    add_point('0, '0, '0);
    add_point('1, '1, '1);
    add_point(24'h80_0000, 24'h40_0000, 24'hC0_0000);
    add_point(24'h84_8C4C, 24'h00_4000, 24'h00_8000);
    add_point(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
    add_random(120);
    drain();
    write_mode(32'h0);
    add_random(130);
    // hold off until the pipeline is empty
    drain();
    add_random(120);
    drain();
    send_idle_pct = 88;
    recv_idle_pct = 31;
    write_mode(32'h1);
    add_random(120);
    drain();
    write_mode(32'h0);
    add_random(120);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(60);
    drain();
    write_mode(32'h1);
    add_random(60);
    drain();
    $display("checked %0d samples, %0d in turbulence mode, both idle mixes and full rate",
             checked_count, turb_count);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
